@@ sv/mesi_pkg.sv @@
package mesi_pkg;

    localparam int P_CNT = 16;
    localparam int IDX_W = (P_CNT > 1) ? $clog2(P_CNT) : 1;
    localparam int EXT_W = 12;
    localparam int PROC_W = 4;
    localparam int WORD_W = 32;

    typedef logic [1:0] t_mesi;
    typedef logic [1:0] t_func;
    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0] t_idx;

    localparam t_mesi ST_M = 2'd0;
    localparam t_mesi ST_E = 2'd1;
    localparam t_mesi ST_S = 2'd2;
    localparam t_mesi ST_I = 2'd3;

    localparam t_func F_READ  = 2'd0;
    localparam t_func F_WRITE = 2'd1;
    localparam t_func F_EVICT = 2'd2;

    localparam t_word MEM_RESET = 32'sd15213;

endpackage

@@ sv/mesi_if.sv @@
interface mesi_req_if;
    import mesi_pkg::*;
    logic                valid;
    logic                ready;
    t_func               func;
    logic [PROC_W-1:0]   processor;
    t_word               write_data;

    modport source (output valid, output func, output processor, output write_data,
                    input ready);
    modport sink   (input valid, input func, input processor, input write_data,
                    output ready);
endinterface

interface mesi_rsp_if;
    import mesi_pkg::*;
    logic                valid;
    logic                ready;
    logic                accepted;
    t_word               read_data;
    t_mesi               requester_state;
    t_word               memory_data;

    modport source (output valid, output accepted, output read_data,
                    output requester_state, output memory_data, input ready);
    modport sink   (input valid, input accepted, input read_data,
                    input requester_state, input memory_data, output ready);
endinterface

@@ sv/mesi_single_line_coherence.sv @@
// mesi coherence controller for one line shared by P_CNT private caches
//
// i_req carries one request (func, processor, write_data) with valid/ready;
// o_rsp returns one response per request (accepted, read_data,
// requester_state, memory_data) with valid/ready.
//
// a request is taken only while the controller is idle. hits and simple
// evicts finish without a scan of the peers; read misses, write misses,
// writes on a shared line and evicts of a shared line walk the peer caches
// one entry per cycle through a single index counter and a value store
// with one read port and one write port.
//
// the response sits in an output register, so the next request is taken
// while a finished response waits; if that register is still full when the
// following request completes, the controller holds until o_rsp is taken.
//
// reset (synchronous, active low) sets every cache to invalid and the
// memory word to 15213.
module mesi_single_line_coherence
    import mesi_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    mesi_req_if.sink        i_req,
    mesi_rsp_if.source      o_rsp
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOOK  = 4'd1;
    localparam logic [3:0] S_HIT   = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_FETCH = 4'd4;
    localparam logic [3:0] S_SWEEP = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_EVM   = 4'd7;
    localparam logic [3:0] S_COUNT = 4'd8;
    localparam logic [3:0] S_PROMO = 4'd9;
    localparam logic [3:0] S_RES   = 4'd10;

    localparam t_idx LAST_IDX = IDX_W'(P_CNT - 1);

    logic [3:0] r_fsm, n_fsm;
    t_idx       r_idx, n_idx;
    t_idx       r_p, n_p;
    t_func      r_func, n_func;
    t_word      r_data, n_data;
    t_mesi      r_stp, n_stp;
    t_mesi      r_hst, n_hst;
    logic       r_found, n_found;
    logic       r_wb, n_wb;
    logic [1:0] r_cnt, n_cnt;
    t_idx       r_last, n_last;
    logic       r_acc, n_acc;
    t_word      r_rd, n_rd;
    t_mesi      r_rs, n_rs;
    t_word      r_mem, n_mem;

    logic       r_ov, n_ov;
    logic       r_oacc, n_oacc;
    t_word      r_ord, n_ord;
    t_mesi      r_ors, n_ors;
    t_word      r_omem, n_omem;

    t_mesi      r_st [P_CNT];
    t_word      r_vals [P_CNT];
    t_word      r_rdata;

    logic             w_st_we;
    t_idx             w_st_addr;
    t_mesi            w_st_wd;
    logic             w_v_we;
    t_word            w_v_wd;
    t_mesi            w_cur;
    logic [EXT_W-1:0] w_p_ext;
    logic             w_in_range;

    assign w_cur      = r_st[r_idx];
    assign w_p_ext    = EXT_W'(i_req.processor);
    assign w_in_range = (w_p_ext < EXT_W'(P_CNT));

    assign i_req.ready           = (r_fsm == S_IDLE);
    assign o_rsp.valid           = r_ov;
    assign o_rsp.accepted        = r_oacc;
    assign o_rsp.read_data       = r_ord;
    assign o_rsp.requester_state = r_ors;
    assign o_rsp.memory_data     = r_omem;

    always_comb begin
        n_fsm   = r_fsm;
        n_idx   = r_idx;
        n_p     = r_p;
        n_func  = r_func;
        n_data  = r_data;
        n_stp   = r_stp;
        n_hst   = r_hst;
        n_found = r_found;
        n_wb    = 1'b0;
        n_cnt   = r_cnt;
        n_last  = r_last;
        n_acc   = r_acc;
        n_rd    = r_rd;
        n_rs    = r_rs;
        n_mem   = r_mem;
        n_ov    = r_ov && !o_rsp.ready;
        n_oacc  = r_oacc;
        n_ord   = r_ord;
        n_ors   = r_ors;
        n_omem  = r_omem;

        w_st_we   = 1'b0;
        w_st_addr = r_p;
        w_st_wd   = ST_I;
        w_v_we    = 1'b0;
        w_v_wd    = r_data;

        // write-back of the first modified holder found during a sweep
        if (r_wb) begin
            n_mem = r_rdata;
        end

        case (r_fsm)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_p    = w_p_ext[IDX_W-1:0];
                    n_idx  = w_p_ext[IDX_W-1:0];
                    n_func = i_req.func;
                    n_data = i_req.write_data;
                    n_rd   = '0;
                    if (w_in_range) begin
                        n_fsm = S_LOOK;
                    end else begin
                        n_acc = 1'b0;
                        n_rs  = ST_I;
                        n_fsm = S_RES;
                    end
                end
            end
            S_LOOK: begin
                n_stp   = w_cur;
                n_acc   = 1'b1;
                n_found = 1'b0;
                n_cnt   = 2'd0;
                case (r_func)
                    F_READ: begin
                        if (w_cur != ST_I) begin
                            n_fsm = S_HIT;
                        end else begin
                            n_idx = '0;
                            n_fsm = S_SCAN;
                        end
                    end
                    F_WRITE: begin
                        n_rs = ST_M;
                        if (w_cur == ST_M || w_cur == ST_E) begin
                            n_fsm = S_UPD;
                        end else begin
                            n_idx = '0;
                            n_fsm = S_SWEEP;
                        end
                    end
                    F_EVICT: begin
                        n_rs = ST_I;
                        if (w_cur == ST_I) begin
                            n_acc = 1'b0;
                            n_fsm = S_RES;
                        end else if (w_cur == ST_M) begin
                            n_fsm = S_EVM;
                        end else begin
                            w_st_we = 1'b1;
                            w_st_wd = ST_I;
                            if (w_cur == ST_S) begin
                                n_idx = '0;
                                n_fsm = S_COUNT;
                            end else begin
                                n_fsm = S_RES;
                            end
                        end
                    end
                    default: begin
                        n_acc = 1'b0;
                        n_rs  = w_cur;
                        n_fsm = S_RES;
                    end
                endcase
            end
            S_HIT: begin
                n_rd  = r_rdata;
                n_rs  = r_stp;
                n_fsm = S_RES;
            end
            S_SCAN: begin
                if (r_idx != r_p && w_cur != ST_I) begin
                    n_hst = w_cur;
                    n_fsm = S_FETCH;
                end else if (r_idx == LAST_IDX) begin
                    w_v_we = 1'b1;
                    w_v_wd = r_mem;
                    n_rd   = r_mem;
                    n_rs   = ST_E;
                    n_fsm  = S_UPD;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FETCH: begin
                if (r_hst == ST_M) begin
                    n_mem = r_rdata;
                end
                w_st_we   = 1'b1;
                w_st_addr = r_idx;
                w_st_wd   = ST_S;
                w_v_we    = 1'b1;
                w_v_wd    = r_rdata;
                n_rd      = r_rdata;
                n_rs      = ST_S;
                n_fsm     = S_UPD;
            end
            S_SWEEP: begin
                if (r_idx != r_p) begin
                    w_st_we   = 1'b1;
                    w_st_addr = r_idx;
                    w_st_wd   = ST_I;
                    if (r_stp == ST_I && !r_found && w_cur != ST_I) begin
                        n_found = 1'b1;
                        n_wb    = (w_cur == ST_M);
                    end
                end
                if (r_idx == LAST_IDX) begin
                    n_fsm = S_UPD;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_UPD: begin
                w_st_we = 1'b1;
                w_st_wd = r_rs;
                if (r_func == F_WRITE) begin
                    w_v_we = 1'b1;
                    w_v_wd = r_data;
                end
                n_fsm = S_RES;
            end
            S_EVM: begin
                n_mem   = r_rdata;
                w_st_we = 1'b1;
                w_st_wd = ST_I;
                n_fsm   = S_RES;
            end
            S_COUNT: begin
                if (w_cur == ST_S) begin
                    n_last = r_idx;
                    if (r_cnt != 2'd2) begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
                if (r_idx == LAST_IDX) begin
                    n_fsm = S_PROMO;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_PROMO: begin
                if (r_cnt == 2'd1) begin
                    w_st_we   = 1'b1;
                    w_st_addr = r_last;
                    w_st_wd   = ST_E;
                end
                n_fsm = S_RES;
            end
            S_RES: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov   = 1'b1;
                    n_oacc = r_acc;
                    n_ord  = r_rd;
                    n_ors  = r_rs;
                    n_omem = r_mem;
                    n_fsm  = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= S_IDLE;
            r_wb    <= 1'b0;
            r_ov    <= 1'b0;
            r_mem   <= MEM_RESET;
            for (int k = 0; k < P_CNT; k++) begin
                r_st[k] <= ST_I;
            end
        end else begin
            r_fsm <= n_fsm;
            r_wb  <= n_wb;
            r_ov  <= n_ov;
            r_mem <= n_mem;
            if (w_st_we) begin
                r_st[w_st_addr] <= w_st_wd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_p     <= n_p;
        r_func  <= n_func;
        r_data  <= n_data;
        r_stp   <= n_stp;
        r_hst   <= n_hst;
        r_found <= n_found;
        r_cnt   <= n_cnt;
        r_last  <= n_last;
        r_acc   <= n_acc;
        r_rd    <= n_rd;
        r_rs    <= n_rs;
        r_oacc  <= n_oacc;
        r_ord   <= n_ord;
        r_ors   <= n_ors;
        r_omem  <= n_omem;
    end

    // cached data words: entries of invalid caches are never read back
    always_ff @(posedge i_clk) begin
        if (w_v_we) begin
            r_vals[r_p] <= w_v_wd;
        end
        r_rdata <= r_vals[r_idx];
    end

endmodule
